// File: hw/rtl/apf_pkg.sv
package apf_pkg;
	localparam logic REQ_EDGE    = 1'b0;
	localparam logic REQ_COMPUTE = 1'b1;
	localparam int   FIELD_W     = 7;
	localparam logic [1:0] REG_VERTEX_COUNT = 2'd0;
	localparam logic [6:0] VC_RESET = 7'd64;

	typedef struct packed {
		logic       req_type;
		logic [6:0] end_a;
		logic [6:0] end_b;
	} apf_in_t;

	typedef struct packed {
		logic [6:0] cut_vertex;
		logic       has_vertex;
		logic [6:0] point_count;
		logic       last;
	} apf_out_t;
endpackage

// File: hw/rtl/apf_if.sv
interface apf_in_if import apf_pkg::*; ();
	logic    valid;
	logic    ready;
	apf_in_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface apf_out_if import apf_pkg::*; ();
	logic     valid;
	logic     ready;
	apf_out_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: hw/rtl/apf_adj_mem.sv
// adjacency row memory, one write port, one registered read port
module apf_adj_mem #(
	parameter int N = 64,
	parameter int AW = 6
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [N-1:0]  wdata,
	input  logic [AW-1:0] raddr,
	output logic [N-1:0]  rdata
);
	logic [N-1:0] mem [N];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

// File: hw/rtl/apf_vtx_mem.sv
// per-vertex entry time and low link memory
module apf_vtx_mem #(
	parameter int N = 64,
	parameter int AW = 6
) (
	input  logic            clk,
	input  logic            we,
	input  logic [AW-1:0]   waddr,
	input  logic [2*AW-1:0] wdata,
	input  logic [AW-1:0]   raddr,
	output logic [2*AW-1:0] rdata
);
	logic [2*AW-1:0] mem [N];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

// File: hw/rtl/articulation_point_finder_top.sv
// Articulation point finder. Edges arrive one per input beat (req_type 0) and are
// folded into an adjacency matrix held in a row memory; each accepted edge does a
// read-modify-write of both endpoint rows, and an ignored edge is dropped. A compute
// beat (req_type 1) runs an iterative depth-first search whose cost is set by the single
// adjacency read port: every stack step reads one row and scans it. A tree edge costs
// a push, the parent skip from the child, the child's final scan and the pop, a back
// edge is seen once from each end, all on top of a root sweep, a count pass and an
// emit pass over the vertices. The emit pass gives one output beat per cut vertex in
// ascending order, or a single beat with has_vertex clear when there is none, and waits
// while the output is stalled; a clearing pass over the matrix follows.
// After reset the matrix is cleared before the first input beat is accepted.
// The walk stack sits in its own memory, one word per level holding the parent of that
// level's vertex and its neighbour cursor. Configuration writes belong between requests,
// once the last result beat has gone and the clearing pass is over.
module articulation_point_finder_top
	import apf_pkg::*;
#(
	parameter int MAX_VERTICES = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	apf_in_if.sink      in_ch,
	apf_out_if.source   out_ch,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	localparam int N  = MAX_VERTICES;
	localparam int AW = (N > 1) ? $clog2(N) : 1;
	localparam int CW = AW + 1;
	localparam int SW = AW + CW;

	localparam logic [3:0] ST_CLEAR  = 4'd0;
	localparam logic [3:0] ST_IDLE   = 4'd1;
	localparam logic [3:0] ST_EDGE_A = 4'd2;
	localparam logic [3:0] ST_EDGE_B = 4'd3;
	localparam logic [3:0] ST_ROOT   = 4'd4;
	localparam logic [3:0] ST_READ   = 4'd5;
	localparam logic [3:0] ST_SCAN   = 4'd6;
	localparam logic [3:0] ST_BACK   = 4'd7;
	localparam logic [3:0] ST_POP    = 4'd8;
	localparam logic [3:0] ST_POP2   = 4'd9;
	localparam logic [3:0] ST_COUNT  = 4'd10;
	localparam logic [3:0] ST_EMIT   = 4'd11;
	localparam logic [3:0] ST_OUT    = 4'd12;

	logic [3:0]    state_q;
	logic [6:0]    vc_q;
	logic [CW-1:0] n_eff;

	// configuration port
	assign pready = 1'b1;
	assign prdata = {25'd0, vc_q};
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vc_q <= VC_RESET;
		else if (psel && penable && pwrite && paddr[2] == REG_VERTEX_COUNT[0])
			vc_q <= pwdata[6:0];
	end
	always_comb begin
		if ({{(CW > 7 ? CW-7 : 0){1'b0}}, vc_q} > (CW > 7 ? CW : 7)'(N))
			n_eff = CW'(N);
		else
			n_eff = CW'(vc_q);
	end

	// memories
	logic          adj_we;
	logic [AW-1:0] adj_wa, adj_ra;
	logic [N-1:0]  adj_wd, adj_rd;
	logic          vtx_we;
	logic [AW-1:0] vtx_wa, vtx_ra;
	logic [2*AW-1:0] vtx_wd, vtx_rd;

	apf_adj_mem #(.N(N), .AW(AW)) u_adj (
		.clk(clk), .we(adj_we), .waddr(adj_wa), .wdata(adj_wd),
		.raddr(adj_ra), .rdata(adj_rd)
	);
	apf_vtx_mem #(.N(N), .AW(AW)) u_vtx (
		.clk(clk), .we(vtx_we), .waddr(vtx_wa), .wdata(vtx_wd),
		.raddr(vtx_ra), .rdata(vtx_rd)
	);

	// search state; top of stack, its parent and its cursor in registers,
	// lower levels in the stack memory
	logic [N-1:0]  visited_q, cut_q;
	logic [SW-1:0] stk_mem [N];
	logic [SW-1:0] stk_rd;
	logic          stk_we;
	logic [AW-1:0] stk_ra;
	logic [AW-1:0] top_q, par_q;
	logic [CW-1:0] cur_q;
	logic [CW-1:0] sp_q;
	logic [AW-1:0] clk_q;
	logic [AW-1:0] root_q;
	logic          root_multi_q, root_one_q;
	logic [CW-1:0] vi_q;
	logic [AW-1:0] a_q, b_q;
	logic [AW-1:0] lo_q, en_q;
	logic [6:0]    total_q;
	logic [6:0]    emitted_q;
	apf_out_t      obuf_q;
	logic          ovalid_q;

	// first set bit of the row just read, at or above the cursor and below the vertex count
	logic [N-1:0]  scan_mask;
	logic          scan_hit;
	logic [AW-1:0] scan_w;
	always_comb begin
		for (int i = 0; i < N; i++)
			scan_mask[i] = adj_rd[i] && (CW'(i) >= cur_q) && (CW'(i) < n_eff);
		scan_hit = |scan_mask;
		scan_w = '0;
		for (int i = N-1; i >= 0; i--)
			if (scan_mask[i])
				scan_w = AW'(i);
	end

	logic [AW-1:0] top_v, par_v;
	assign top_v = top_q;
	assign par_v = par_q;

	// push saves the parent and the advanced cursor of the current top
	assign stk_we = (state_q == ST_SCAN) && scan_hit && !visited_q[scan_w] && sp_q < CW'(N);
	assign stk_ra = sp_q[AW-1:0] - AW'(2);
	always_ff @(posedge clk) begin
		if (stk_we)
			stk_mem[sp_q[AW-1:0] - AW'(1)] <= {par_q, CW'(scan_w) + CW'(1)};
		stk_rd <= stk_mem[stk_ra];
	end

	logic in_fire, edge_ok;
	assign in_fire = in_ch.valid && in_ch.ready;
	assign in_ch.ready = (state_q == ST_IDLE);
	assign edge_ok = in_ch.data.end_a != in_ch.data.end_b
		&& in_ch.data.end_a != 7'd0 && in_ch.data.end_b != 7'd0
		&& {{(CW > 7 ? CW-7 : 0){1'b0}}, in_ch.data.end_a} <= (CW > 7 ? CW : 7)'(n_eff)
		&& {{(CW > 7 ? CW-7 : 0){1'b0}}, in_ch.data.end_b} <= (CW > 7 ? CW : 7)'(n_eff);

	logic out_free;
	assign out_free = !ovalid_q || out_ch.ready;
	assign out_ch.valid = ovalid_q;
	assign out_ch.data = obuf_q;

	// memory port control
	always_comb begin
		adj_we = 1'b0;
		adj_wa = '0;
		adj_wd = '0;
		adj_ra = '0;
		vtx_we = 1'b0;
		vtx_wa = '0;
		vtx_wd = '0;
		vtx_ra = top_v;
		case (state_q)
			ST_CLEAR: begin
				adj_we = 1'b1;
				adj_wa = vi_q[AW-1:0];
			end
			ST_IDLE:
				adj_ra = AW'(in_ch.data.end_a - 7'd1);
			ST_EDGE_A: begin
				adj_we = 1'b1;
				adj_wa = a_q;
				adj_wd = adj_rd | (N'(1) << b_q);
				adj_ra = b_q;
			end
			ST_EDGE_B: begin
				adj_we = 1'b1;
				adj_wa = b_q;
				adj_wd = adj_rd | (N'(1) << a_q);
			end
			ST_ROOT: begin
				vtx_we = !visited_q[vi_q[AW-1:0]] && vi_q < n_eff;
				vtx_wa = vi_q[AW-1:0];
				vtx_wd = {clk_q, clk_q};
				adj_ra = vi_q[AW-1:0];
			end
			ST_READ:
				adj_ra = top_v;
			ST_SCAN: begin
				vtx_we = scan_hit && !visited_q[scan_w];
				vtx_wa = scan_w;
				vtx_wd = {clk_q, clk_q};
				vtx_ra = scan_w;
			end
			ST_BACK: begin
				vtx_we = 1'b1;
				vtx_wa = top_v;
				vtx_wd = {en_q, (vtx_rd[2*AW-1:AW] < lo_q) ? vtx_rd[2*AW-1:AW] : lo_q};
			end
			ST_POP:
				vtx_ra = par_v;
			ST_POP2: begin
				// top already moved back to the parent
				vtx_we = lo_q < vtx_rd[AW-1:0];
				vtx_wa = top_v;
				vtx_wd = {vtx_rd[2*AW-1:AW], lo_q};
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				a_q <= AW'(in_ch.data.end_a - 7'd1);
				b_q <= AW'(in_ch.data.end_b - 7'd1);
			end
			ST_ROOT:
				if (!visited_q[vi_q[AW-1:0]] && vi_q < n_eff) begin
					top_q <= vi_q[AW-1:0];
					par_q <= vi_q[AW-1:0];
					cur_q <= '0;
				end
			ST_SCAN: begin
				// top vertex low/entry, read in the cycle before
				lo_q <= vtx_rd[AW-1:0];
				en_q <= vtx_rd[2*AW-1:AW];
				if (scan_hit) begin
					if (!visited_q[scan_w] && sp_q < CW'(N)) begin
						par_q <= top_q;
						top_q <= scan_w;
						cur_q <= '0;
					end else
						cur_q <= CW'(scan_w) + CW'(1);
				end
			end
			ST_POP:
				top_q <= par_q;
			ST_POP2: begin
				par_q <= stk_rd[SW-1:CW];
				cur_q <= stk_rd[CW-1:0];
			end
			default: ;
		endcase
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			vi_q <= '0;
			visited_q <= '0;
			cut_q <= '0;
			sp_q <= '0;
			clk_q <= '0;
			root_q <= '0;
			root_multi_q <= 1'b0;
			root_one_q <= 1'b0;
			total_q <= '0;
			emitted_q <= '0;
			ovalid_q <= 1'b0;
			obuf_q <= '0;
		end else begin
			if (ovalid_q && out_ch.ready)
				ovalid_q <= 1'b0;
			case (state_q)
				ST_CLEAR: begin
					if (vi_q == CW'(N-1)) begin
						vi_q <= '0;
						state_q <= ST_IDLE;
					end else
						vi_q <= vi_q + CW'(1);
				end
				ST_IDLE:
					if (in_fire) begin
						if (in_ch.data.req_type == REQ_COMPUTE) begin
							vi_q <= '0;
							clk_q <= '0;
							state_q <= ST_ROOT;
						end else if (edge_ok)
							state_q <= ST_EDGE_A;
					end
				ST_EDGE_A:
					state_q <= ST_EDGE_B;
				ST_EDGE_B:
					state_q <= ST_IDLE;
				ST_ROOT: begin
					if (vi_q >= n_eff) begin
						vi_q <= '0;
						total_q <= '0;
						state_q <= ST_COUNT;
					end else if (!visited_q[vi_q[AW-1:0]]) begin
						visited_q[vi_q[AW-1:0]] <= 1'b1;
						clk_q <= clk_q + AW'(1);
						root_q <= vi_q[AW-1:0];
						root_one_q <= 1'b0;
						root_multi_q <= 1'b0;
						sp_q <= CW'(1);
						state_q <= ST_READ;
					end else
						vi_q <= vi_q + CW'(1);
				end
				ST_READ:
					state_q <= ST_SCAN;
				ST_SCAN:
					if (scan_hit) begin
						if (!visited_q[scan_w]) begin
							visited_q[scan_w] <= 1'b1;
							clk_q <= clk_q + AW'(1);
							if (top_v == root_q) begin
								if (root_one_q)
									root_multi_q <= 1'b1;
								root_one_q <= 1'b1;
							end
							if (sp_q < CW'(N))
								sp_q <= sp_q + CW'(1);
							state_q <= ST_READ;
						end else if (sp_q >= CW'(2) && par_v == scan_w)
							state_q <= ST_READ;
						else
							state_q <= ST_BACK;
					end else
						state_q <= ST_POP;
				ST_BACK:
					state_q <= ST_READ;
				ST_POP: begin
					sp_q <= sp_q - CW'(1);
					if (sp_q == CW'(1)) begin
						if (root_multi_q)
							cut_q[root_q] <= 1'b1;
						vi_q <= vi_q + CW'(1);
						state_q <= ST_ROOT;
					end else
						state_q <= ST_POP2;
				end
				ST_POP2: begin
					// sp already points at parent level
					if (top_v != root_q && lo_q >= vtx_rd[2*AW-1:AW])
						cut_q[top_v] <= 1'b1;
					state_q <= ST_READ;
				end
				ST_COUNT: begin
					if (vi_q >= n_eff) begin
						vi_q <= '0;
						emitted_q <= '0;
						state_q <= ST_EMIT;
					end else begin
						if (cut_q[vi_q[AW-1:0]] && total_q != 7'd127)
							total_q <= total_q + 7'd1;
						vi_q <= vi_q + CW'(1);
					end
				end
				ST_EMIT:
					if (out_free) begin
						if (total_q == 7'd0) begin
							obuf_q <= '{cut_vertex: 7'd0, has_vertex: 1'b0,
								point_count: 7'd0, last: 1'b1};
							ovalid_q <= 1'b1;
							state_q <= ST_OUT;
						end else if (vi_q >= n_eff || emitted_q == 7'd64)
							state_q <= ST_OUT;
						else begin
							if (cut_q[vi_q[AW-1:0]]) begin
								obuf_q <= '{cut_vertex: 7'(vi_q + CW'(1)), has_vertex: 1'b1,
									point_count: total_q,
									last: (emitted_q + 7'd1 == total_q) || emitted_q == 7'd63};
								ovalid_q <= 1'b1;
								emitted_q <= emitted_q + 7'd1;
							end
							vi_q <= vi_q + CW'(1);
						end
					end
				ST_OUT: begin
					visited_q <= '0;
					cut_q <= '0;
					vi_q <= '0;
					state_q <= ST_CLEAR;
				end
				default:
					state_q <= ST_CLEAR;
			endcase
		end
	end

	// assertions
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |-> state_q == ST_IDLE)
		else $error("input beat taken while busy");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.data))
		else $error("output beat dropped");
	a_sp_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN || state_q == ST_READ) |-> sp_q != '0)
		else $error("stack empty during walk");
endmodule
